[hdl/lkvc_pkg.sv]
// shared types and constants for the lru key-value cache
// no dependencies; imported by lkvc_cell, lkvc_ctrl and lru_key_value_cache_core
package lkvc_pkg;

	// sizing of the store
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	// fixed field widths on the stream ports
	localparam int KEY_FIELD_BITS   = 32;
	localparam int VALUE_FIELD_BITS = 32;
	localparam int S_DATA_BITS      = KEY_FIELD_BITS + VALUE_FIELD_BITS;
	localparam int S_USER_BITS      = 1;
	localparam int M_DATA_BITS      = VALUE_FIELD_BITS;
	localparam int M_USER_BITS      = 1;
	localparam int CAP_BITS         = 5;

	// occupancy counter and the wider compare domain shared with capacity
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);
	localparam int WIDE_BITS = ((OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS) + 1;

	// reset value of the capacity register
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	// action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	// one stored entry, kept in recency order along the cell chain
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	// per-cell strobes from the controller
	typedef struct packed {
		logic cmp;   // register the key match
		logic take;  // load the entry handed over by the neighbor
	} cell_ctrl_t;

endpackage

[hdl/lkvc_cell.sv]
// one recency position of the cache: entry storage plus key comparator
// depends on lkvc_pkg
module lkvc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkvc_pkg::cell_ctrl_t          ctrl,
	input  logic [lkvc_pkg::KEY_BITS-1:0] cmp_key,
	input  lkvc_pkg::entry_t              prev,
	output lkvc_pkg::entry_t              entry,
	output logic                          match
);
	import lkvc_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  match_q;

	// valid flag is control state and is cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.take) begin
				valid_q <= prev.valid;
			end
			if (ctrl.cmp) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
		end
	end

	// payload moves one position down the chain when taken
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.value = value_q;
	assign match       = match_q;

endmodule

[hdl/lkvc_ctrl.sv]
// sequencer for the cell chain: item capture, hit resolve, shift mask, occupancy, output word
// depends on lkvc_pkg
module lkvc_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config
	input  logic                                  cfg_we,
	input  logic [lkvc_pkg::CAP_BITS-1:0]         cfg_wdata,
	// input word
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lkvc_pkg::S_DATA_BITS-1:0]      s_tdata,
	input  logic [lkvc_pkg::S_USER_BITS-1:0]      s_tuser,
	// output word
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lkvc_pkg::M_DATA_BITS-1:0]      m_tdata,
	output logic [lkvc_pkg::M_USER_BITS-1:0]      m_tuser,
	// cell chain
	input  lkvc_pkg::entry_t                      entries [lkvc_pkg::ENTRIES],
	input  logic [lkvc_pkg::ENTRIES-1:0]          match,
	output lkvc_pkg::cell_ctrl_t                  cell_ctrl [lkvc_pkg::ENTRIES],
	output logic [lkvc_pkg::KEY_BITS-1:0]         cmp_key,
	output lkvc_pkg::entry_t                      new_entry
);
	import lkvc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]            state_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic [M_DATA_BITS-1:0] rdata_q;

	logic                  act_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] wval_s1;

	logic                  accept;
	logic                  commit;
	logic                  hit;
	logic [VALUE_BITS-1:0] hit_value;
	logic [WIDE_BITS-1:0]  occ_w;
	logic [WIDE_BITS-1:0]  cap_w;
	logic                  full;
	logic                  no_room;
	logic                  load;
	logic [WIDE_BITS-1:0]  shift_lim;
	logic [ENTRIES-1:0]    valid_vec;

	assign commit   = (state_q == ST_UPD) && (!out_valid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE) || commit;
	assign accept   = s_tvalid && s_tready;

	// hit value: and-or over the registered match bits
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_value = hit_value | (entries[i].value & {VALUE_BITS{match[i]}});
		end
	end

	assign hit = |match;

	// capacity clamp and eviction decision
	assign occ_w   = WIDE_BITS'(occ_q);
	assign cap_w   = (WIDE_BITS'(cap_q) > WIDE_BITS'(ENTRIES)) ? WIDE_BITS'(ENTRIES)
	                                                           : WIDE_BITS'(cap_q);
	assign full    = (occ_w + WIDE_BITS'(1)) > cap_w;
	assign no_room = full && (occ_q == '0);
	assign load    = (state_q == ST_UPD) && commit &&
	                 (hit || ((act_s1 == ACT_SET) && !no_room));
	// miss with eviction drops the last valid position; otherwise the chain grows by one
	assign shift_lim = full ? occ_w : (occ_w + WIDE_BITS'(1));

	// entry handed to the head of the chain
	assign cmp_key         = key_s1;
	assign new_entry.valid = 1'b1;
	assign new_entry.key   = key_s1;
	assign new_entry.value = (act_s1 == ACT_SET) ? wval_s1 : hit_value;

	// per-cell strobes
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			cell_ctrl[i].cmp = (state_q == ST_CMP);
			if (i == 0) begin
				cell_ctrl[i].take = load;
			end else if (hit) begin
				cell_ctrl[i].take = load && (|(match >> i));
			end else begin
				cell_ctrl[i].take = load && (WIDE_BITS'(i) < shift_lim);
			end
		end
	end

	// sequencer, occupancy and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (!hit && (act_s1 == ACT_SET) && !full) begin
					occ_q <= occ_q + OCC_BITS'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (accept) begin
						state_q <= ST_CMP;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= s_tuser[0];
			key_s1  <= KEY_BITS'(s_tdata[KEY_FIELD_BITS-1:0]);
			wval_s1 <= VALUE_BITS'(s_tdata[S_DATA_BITS-1:KEY_FIELD_BITS]);
		end
		if (commit) begin
			found_q <= hit;
			rdata_q <= (hit && (act_s1 == ACT_GET)) ? M_DATA_BITS'(hit_value) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rdata_q;
	assign m_tuser  = M_USER_BITS'(found_q);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_vec[i] = entries[i].valid;
		end
	end

`ifndef SYNTHESIS
	// keys are unique among valid entries, so at most one cell matches
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $onehot0(match))
		else $error("more than one cell matched the key");

	// valid entries fill the head of the chain and agree with the counter
	assert property (@(posedge clk) disable iff (!arst_n)
		($countones(valid_vec) == int'(occ_q)) &&
		((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
		else $error("valid cells not contiguous or occupancy out of step");

	// occupancy never passes the number of cells
	assert property (@(posedge clk) disable iff (!arst_n)
		WIDE_BITS'(occ_q) <= WIDE_BITS'(ENTRIES))
		else $error("occupancy above cell count");

	// no new word is taken while the key match is being registered
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> !s_tready)
		else $error("input ready during compare");
`endif

endmodule

[hdl/lru_key_value_cache_core.sv]
// top level of the lru key-value cache: controller plus chain of recency cells
// depends on lkvc_pkg, lkvc_cell, lkvc_ctrl
//
// channel  dir  handshake         payload
// s_*      in   tvalid/tready     tdata = lookup_key, write_value; tuser = action
// m_*      out  tvalid/tready     tdata = read_value; tuser = found
// cfg_*    in   cfg_we            cfg_wdata = capacity
//
// an item passes the compare state, registering the key match in every cell, then
// update, resolving the hit and shifting the chain (recency order) by one place.
// a stalled output word holds the chain in the update cycle until taken.
// reset clears all valid flags and occupancy; capacity resets to 16.
module lru_key_value_cache_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lkvc_pkg::CAP_BITS-1:0]        cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// lookup_key [31:0], write_value [63:32]
	input  logic [lkvc_pkg::S_DATA_BITS-1:0]     s_tdata,
	// action [0]
	input  logic [lkvc_pkg::S_USER_BITS-1:0]     s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// read_value [31:0]
	output logic [lkvc_pkg::M_DATA_BITS-1:0]     m_tdata,
	// found [0]
	output logic [lkvc_pkg::M_USER_BITS-1:0]     m_tuser
);
	import lkvc_pkg::*;

	entry_t              entries   [ENTRIES];
	entry_t              prevs     [ENTRIES];
	cell_ctrl_t          cell_ctrl [ENTRIES];
	logic [ENTRIES-1:0]  match;
	logic [KEY_BITS-1:0] cmp_key;
	entry_t              new_entry;

	// controller
	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.entries   (entries),
		.match     (match),
		.cell_ctrl (cell_ctrl),
		.cmp_key   (cmp_key),
		.new_entry (new_entry)
	);

	// chain of cells, most recent at position zero
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prevs[i] = new_entry;
		end else begin : g_body
			assign prevs[i] = entries[i-1];
		end

		lkvc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl[i]),
			.cmp_key (cmp_key),
			.prev    (prevs[i]),
			.entry   (entries[i]),
			.match   (match[i])
		);
	end

endmodule

[verif/lkvc_checker.sv]
`timescale 1ns / 1ps
// response checker for lru_key_value_cache_core: tracks the capacity writes and input words,
// keeps its own recency-ordered store and compares every output word in order
// depends on lkvc_pkg
module lkvc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lkvc_pkg::CAP_BITS-1:0]    cfg_wdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [lkvc_pkg::S_DATA_BITS-1:0] s_tdata,
	input  logic [lkvc_pkg::S_USER_BITS-1:0] s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [lkvc_pkg::M_DATA_BITS-1:0] m_tdata,
	input  logic [lkvc_pkg::M_USER_BITS-1:0] m_tuser,
	output int                               pending_words,
	output int                               mismatches
);
	import lkvc_pkg::*;

	localparam int SLOT_BITS = $clog2(ENTRIES);

	typedef struct packed {
		logic                        found;
		logic [VALUE_FIELD_BITS-1:0] value;
	} answer_t;

	// mirror of the store: slot contents plus the recency list of slot numbers
	logic [KEY_BITS-1:0]   key_store   [ENTRIES];
	logic [VALUE_BITS-1:0] value_store [ENTRIES];
	logic                  slot_live   [ENTRIES];
	logic [SLOT_BITS-1:0]  recency     [ENTRIES];
	int                    live_count;
	logic [CAP_BITS-1:0]   capacity_reg;

	answer_t answer_q[$];
	int      error_tally = 0;

	task automatic clear_store();
		for (int i = 0; i < ENTRIES; i++) begin
			key_store[i]   = '0;
			value_store[i] = '0;
			slot_live[i]   = 1'b0;
			recency[i]     = SLOT_BITS'(i);
		end
		live_count   = 0;
		capacity_reg = CAP_RESET;
	endtask

	// move the slot at list position pos to the front, shifting the ones ahead of it back
	task automatic promote(input int pos);
		logic [SLOT_BITS-1:0] slot;
		slot = recency[pos];
		for (int i = pos; i > 0; i--)
			recency[i] = recency[i-1];
		recency[0] = slot;
	endtask

	// look up one request, update the store and work out the answer word
	task automatic serve_request(input logic act, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] val, output answer_t ans);
		int                   eff_cap;
		int                   pos;
		bit                   hit;
		logic [SLOT_BITS-1:0] slot;
		eff_cap = (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
		hit = 1'b0;
		pos = 0;
		for (int p = 0; p < live_count; p++) begin
			if (!hit && slot_live[recency[p]] && key_store[recency[p]] == key) begin
				hit = 1'b1;
				pos = p;
			end
		end
		ans.found = hit;
		ans.value = '0;
		if (hit) begin
			slot = recency[pos];
			if (act == ACT_GET)
				ans.value = value_store[slot];
			else
				value_store[slot] = val;
			promote(pos);
		end else if (act == ACT_SET && !(live_count == 0 && eff_cap == 0)) begin
			// full: the least recent entry goes first, only one per insertion
			if (live_count + 1 > eff_cap) begin
				live_count--;
				slot_live[recency[live_count]] = 1'b0;
			end
			slot = recency[live_count];
			key_store[slot]   = key;
			value_store[slot] = val;
			slot_live[slot]   = 1'b1;
			promote(live_count);
			live_count++;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("checker: %s mismatch at %0t: got %h, want %h", what, $realtime, got, want);
		error_tally++;
	endtask

	// compare output words first, then model the input word and any capacity write
	always @(posedge clk or negedge arst_n) begin : track
		answer_t ans;
		if (!arst_n) begin
			clear_store();
			answer_q.delete();
			pending_words <= 0;
			mismatches    <= error_tally;
		end else begin
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unrequested word", m_tdata, '0);
				end else begin
					ans = answer_q.pop_front();
					if (m_tuser[0] !== ans.found)
						report_mismatch("found", 32'(m_tuser[0]), 32'(ans.found));
					if (m_tdata !== ans.value)
						report_mismatch("read_value", m_tdata, ans.value);
				end
			end
			if (s_tvalid && s_tready) begin
				serve_request(s_tuser[0], s_tdata[KEY_FIELD_BITS-1:0],
					s_tdata[S_DATA_BITS-1:KEY_FIELD_BITS], ans);
				answer_q.push_back(ans);
			end
			if (cfg_we)
				capacity_reg = cfg_wdata;
			pending_words <= answer_q.size();
			mismatches    <= error_tally;
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// stimulus and verdict for lru_key_value_cache_core: directed and random get/set words
// under changing capacity and idle patterns; depends on lkvc_pkg and lkvc_checker
module testbench;
	import lkvc_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int TAIL_CYCLES = 16;
	localparam int PHASE_ITEMS = 50;
	localparam int PHASES      = 9;
	localparam int POOL_SIZE   = 24;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CAP_BITS-1:0]    cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata   = '0;
	logic [S_USER_BITS-1:0] s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;
	logic [M_USER_BITS-1:0] m_tuser;

	int pending_words;
	int mismatches;
	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	logic hold_req   = 1'b0;
	logic hold_taken = 1'b0;

	logic [KEY_FIELD_BITS-1:0] key_pool   [POOL_SIZE];
	logic [CAP_BITS-1:0]       phase_caps [PHASES];

	always #2 clk = ~clk;

	lru_key_value_cache_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	lkvc_checker answer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.pending_words (pending_words),
		.mismatches    (mismatches)
	);

	// output side: random stalls, plus one long hold-off once the sender is offering
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken && s_tvalid) begin
			m_tready   <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// offer one input word after a random gap, return at the edge it is taken
	task automatic send_word(input logic act, input logic [KEY_FIELD_BITS-1:0] key,
			input logic [VALUE_FIELD_BITS-1:0] val);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, key};
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// stop offering, then wait for the answer queue to empty
	// every word yields an answer, so an empty answer queue means the block is idle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one capacity setting with random gets and sets drawn mostly from a small key pool
	task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int items);
		int                          span;
		logic                        act;
		logic [KEY_FIELD_BITS-1:0]   key;
		logic [VALUE_FIELD_BITS-1:0] val;
		wait_idle();
		write_capacity(cap);
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hffff_ffff;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7fff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		span = ((cap > ENTRIES) ? ENTRIES : int'(cap)) + 4;
		repeat (items) begin
			act = $urandom_range(0, 1) ? ACT_SET : ACT_GET;
			key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
			case ($urandom_range(0, 7))
				0: val = 32'h0000_0000;
				1: val = 32'hffff_ffff;
				2: val = 32'h8000_0000;
				3: val = 32'h7fff_ffff;
				default: val = $urandom;
			endcase
			send_word(act, key, val);
		end
	endtask

	initial begin : stimulus
		phase_caps = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16, 5'd5};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero capacity on an empty store: a set is not stored, so the get after it misses
		write_capacity(5'd0);
		send_word(ACT_SET, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
		send_word(ACT_GET, 32'h5a5a_5a5a, 32'h0000_0000);

		// capacity above the entry count, field extremes, hits, misses and overwrite
		wait_idle();
		write_capacity(5'd31);
		send_word(ACT_GET, 32'h0000_0000, 32'hffff_ffff);
		send_word(ACT_SET, 32'h0000_0000, 32'h7fff_ffff);
		send_word(ACT_SET, 32'h8000_0000, 32'h8000_0000);
		send_word(ACT_SET, 32'hffff_ffff, 32'hffff_ffff);
		send_word(ACT_SET, 32'h7fff_ffff, 32'h0000_0000);
		send_word(ACT_GET, 32'h8000_0000, 32'h0000_0000);
		send_word(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
		send_word(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
		send_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);
		send_word(ACT_SET, 32'h8000_0000, 32'h1234_5678);
		send_word(ACT_GET, 32'h8000_0000, 32'h0000_0000);
		send_word(ACT_GET, 32'h0000_0001, 32'h0000_0000);
		send_word(ACT_SET, 32'h0000_0000, 32'h0000_0000);

		// zero capacity with entries present: a new key replaces the least recent one
		wait_idle();
		write_capacity(5'd0);
		send_word(ACT_SET, 32'h0000_0002, 32'h0000_beef);
		send_word(ACT_GET, 32'h0000_0002, 32'h0000_0000);
		send_word(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
		send_word(ACT_SET, 32'h8000_0000, 32'hdead_0000);
		send_word(ACT_GET, 32'h7fff_ffff, 32'h0000_0000);

		// random phases: sender idles little, then receiver idles little, then neither
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 3)
				0: begin
					tx_idle_pct <= 17;
					rx_idle_pct <= 67;
				end
				1: begin
					tx_idle_pct <= 67;
					rx_idle_pct <= 17;
				end
				default: begin
					tx_idle_pct <= 0;
					rx_idle_pct <= 0;
				end
			endcase
			if (ph == 6)
				hold_req <= 1'b1;
			run_phase(phase_caps[ph], PHASE_ITEMS);
		end

		// drain and verdict
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
